// ===== src/chx_pkg.sv =====
package chx_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int ATAN_LEN         = 24;
    localparam int ANGLE_W          = 32;
    localparam int PRESCALE_W       = 40;
    localparam int CORDIC_W         = 44;
    localparam int CFG_W            = 16;
    localparam int CD_W             = 16;
    localparam int PROD_W           = 48;
    localparam int MID_DEPTH        = 4;
    localparam int OUT_DEPTH        = 2;

    localparam logic [CD_W-1:0] CD_ZERO = 16'd0;
    localparam logic [CD_W-1:0] CD_90   = 16'd9000;
    localparam logic [CD_W-1:0] CD_180  = 16'd18000;
    localparam logic [CD_W-1:0] CD_270  = 16'd27000;
    localparam logic [CD_W-1:0] CD_FULL = 16'd36000;

    localparam logic [ANGLE_W-1:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [PROD_W-1:0]  CD_ROUND   = 48'h0000_8000_0000;
    localparam logic [PROD_W-1:0]  CD_SCALE   = 48'd36000;

    // atan(2^-i) in binary angle units, 2^32 per turn
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic {
        CFG_OFFSET_X = 1'b0,
        CFG_OFFSET_Y = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic            is_fixed;
        logic [CD_W-1:0] fixed_cd;
    } t_cls;

endpackage

// ===== src/chx_fifo.sv =====
module chx_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [NW-1:0]    r_count, n_count;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (wr_ok) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_count = r_count + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== src/chx_front.sv =====
module chx_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [chx_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]  i_mag_x,
    input  logic [SAMPLE_BITS-1:0]  i_mag_y,
    output logic [SAMPLE_BITS:0]    o_hx,
    output logic [SAMPLE_BITS:0]    o_hy,
    output chx_pkg::t_cls           o_cls
);
    import chx_pkg::*;

    logic [CFG_W-1:0]       r_off_x, r_off_y, n_off_x, n_off_y;
    logic [SAMPLE_BITS-1:0] off_x, off_y;
    logic signed [SAMPLE_BITS:0] hx, hy;

    always_comb begin
        n_off_x = r_off_x;
        n_off_y = r_off_y;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFFSET_X: n_off_x = i_cfg_data;
                CFG_OFFSET_Y: n_off_y = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
        end else begin
            r_off_x <= n_off_x;
            r_off_y <= n_off_y;
        end
    end

    assign off_x = SAMPLE_BITS'(r_off_x);
    assign off_y = SAMPLE_BITS'(r_off_y);
    assign hx = $signed({i_mag_x[SAMPLE_BITS-1], i_mag_x})
              - $signed({off_x[SAMPLE_BITS-1], off_x});
    assign hy = $signed({i_mag_y[SAMPLE_BITS-1], i_mag_y})
              - $signed({off_y[SAMPLE_BITS-1], off_y});

    // axis-aligned vectors bypass the CORDIC
    always_comb begin
        o_cls.is_fixed = (hx == '0) || (hy == '0);
        if (hx == '0 && hy == '0) begin
            o_cls.fixed_cd = CD_ZERO;
        end else if (hx == '0) begin
            o_cls.fixed_cd = hy[SAMPLE_BITS] ? CD_90 : CD_270;
        end else begin
            o_cls.fixed_cd = hx[SAMPLE_BITS] ? CD_180 : CD_ZERO;
        end
    end

    assign o_hx = hx;
    assign o_hy = hy;

endmodule

// ===== src/chx_back.sv =====
module chx_back #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_item_valid,
    output logic                    o_item_pop,
    input  logic [SAMPLE_BITS:0]    i_hx,
    input  logic [SAMPLE_BITS:0]    i_hy,
    input  chx_pkg::t_cls           i_cls,
    input  logic                    i_out_full,
    output logic                    o_out_wr,
    output logic [chx_pkg::CD_W-1:0] o_out_cd
);
    import chx_pkg::*;

    localparam int N        = CORDIC_STEPS;
    localparam int PRESHIFT = PRESCALE_W - SAMPLE_BITS;

    logic                       en;
    logic [N:0]                 r_vld;
    logic                       r_pvld;
    logic signed [CORDIC_W-1:0] r_x   [0:N];
    logic signed [CORDIC_W-1:0] r_y   [0:N];
    logic [ANGLE_W-1:0]         r_ang [0:N];
    t_cls                       r_cls [0:N];
    logic signed [CORDIC_W-1:0] n_x   [0:N];
    logic signed [CORDIC_W-1:0] n_y   [0:N];
    logic [ANGLE_W-1:0]         n_ang [0:N];
    logic signed [CORDIC_W-1:0] x_in, y_in;
    logic [ANGLE_W-1:0]         h;
    logic [PROD_W-1:0]          r_prod, sum;
    t_cls                       r_pcls;
    logic [CD_W-1:0]            cd;

    assign en         = !i_out_full;
    assign o_item_pop = en && i_item_valid;

    // stage 0: prescale, fold the left half-plane over by half a turn
    assign x_in = CORDIC_W'($signed(i_hx)) <<< PRESHIFT;
    assign y_in = CORDIC_W'($signed(i_hy)) <<< PRESHIFT;

    always_comb begin
        if (x_in < 0) begin
            n_x[0]   = -x_in;
            n_y[0]   = -y_in;
            n_ang[0] = HALF_TURN;
        end else begin
            n_x[0]   = x_in;
            n_y[0]   = y_in;
            n_ang[0] = '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        always_comb begin
            if (r_y[k] >= 0) begin
                n_x[k+1]   = r_x[k] + (r_y[k] >>> k);
                n_y[k+1]   = r_y[k] - (r_x[k] >>> k);
                n_ang[k+1] = r_ang[k] + ATAN_TURNS[k];
            end else begin
                n_x[k+1]   = r_x[k] - (r_y[k] >>> k);
                n_y[k+1]   = r_y[k] + (r_x[k] >>> k);
                n_ang[k+1] = r_ang[k] - ATAN_TURNS[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[k+1]   <= n_x[k+1];
                r_y[k+1]   <= n_y[k+1];
                r_ang[k+1] <= n_ang[k+1];
                r_cls[k+1] <= r_cls[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]   <= n_x[0];
            r_y[0]   <= n_y[0];
            r_ang[0] <= n_ang[0];
            r_cls[0] <= i_cls;
        end
    end

    assign h = '0 - r_ang[N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= PROD_W'(h) * CD_SCALE;
            r_pcls <= r_cls[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_pvld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[N-1:0], o_item_pop};
            r_pvld <= r_vld[N];
        end
    end

    assign sum      = r_prod + CD_ROUND;
    assign cd       = sum[PROD_W-1:PROD_W-CD_W];
    assign o_out_wr = en && r_pvld;
    assign o_out_cd = r_pcls.is_fixed ? r_pcls.fixed_cd :
                      (cd >= CD_FULL) ? CD_ZERO : cd;

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_wr |-> (o_out_cd < CD_FULL))
        else $error("heading out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_vld) && $stable(r_pvld)))
        else $error("pipeline moved while stalled");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> i_item_valid)
        else $error("pop from empty queue");

endmodule

// ===== src/compass_heading_from_xy_top.sv =====
// Channel   Direction  Handshake               Payload
// input     in         i_push / o_full         i_mag_x, i_mag_y
// result    out        o_empty / i_pop         o_heading_centideg
// config    in         i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the result queue has room; a pushed item passes
// the middle queue, the unrolled CORDIC (one stage per step), multiply and result queue.
// Reset (synchronous, active low) empties both queues and clears the offsets to zero.
// A full result queue freezes the CORDIC pipeline; the middle queue then fills and
// raises o_full.
module compass_heading_from_xy_top #(
    parameter int CORDIC_STEPS = chx_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = chx_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [SAMPLE_BITS-1:0]    i_mag_x,
    input  logic [SAMPLE_BITS-1:0]    i_mag_y,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [chx_pkg::CD_W-1:0]  o_heading_centideg,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [chx_pkg::CFG_W-1:0] i_cfg_data
);
    import chx_pkg::*;

    localparam int HW    = SAMPLE_BITS + 1;
    localparam int MID_W = $bits(t_cls) + 2 * HW;

    logic [HW-1:0]    f_hx, f_hy, b_hx, b_hy;
    t_cls             f_cls, b_cls;
    logic [MID_W-1:0] mid_wdata, mid_rdata;
    logic             mid_empty, mid_pop;
    logic             out_full, out_wr;
    logic [CD_W-1:0]  out_cd;

    chx_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mag_x    (i_mag_x),
        .i_mag_y    (i_mag_y),
        .o_hx       (f_hx),
        .o_hy       (f_hy),
        .o_cls      (f_cls)
    );

    assign mid_wdata = {f_cls, f_hx, f_hy};

    chx_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (mid_wdata),
        .o_full  (o_full),
        .i_rd    (mid_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    assign {b_cls, b_hx, b_hy} = mid_rdata;

    chx_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!mid_empty),
        .o_item_pop   (mid_pop),
        .i_hx         (b_hx),
        .i_hy         (b_hy),
        .i_cls        (b_cls),
        .i_out_full   (out_full),
        .o_out_wr     (out_wr),
        .o_out_cd     (out_cd)
    );

    chx_fifo #(
        .WIDTH (CD_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .i_wdata (out_cd),
        .o_full  (out_full),
        .i_rd    (i_pop),
        .o_rdata (o_heading_centideg),
        .o_empty (o_empty)
    );

endmodule

// ===== tb/sv/tb_compass_heading_from_xy_top.sv =====
module tb_compass_heading_from_xy_top;

    import chx_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int PRESCALE    = 40 - SAMPLE_BITS_DEF;
    localparam int PHASE_ITEMS = 172;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = STEPS + 8;

    // atan(2^-i), 2^32 per turn
    localparam logic [31:0] ATAN_TAB [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    class heading_checker;
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [15:0] expected_headings[$];
        int          errors;

        function new();
            off_x  = '0;
            off_y  = '0;
            errors = 0;
        endfunction

        function void set_offset(t_cfg_idx idx, logic [15:0] value);
            if (idx == CFG_OFFSET_X) begin
                off_x = value;
            end else begin
                off_y = value;
            end
        endfunction

        function logic [15:0] predict_heading(logic [15:0] mx, logic [15:0] my);
            logic signed [16:0] hx;
            logic signed [16:0] hy;
            longint             x;
            longint             y;
            longint             dx;
            longint             dy;
            logic [31:0]        ang;
            logic [63:0]        prod;
            logic [15:0]        cd;
            hx = $signed({mx[15], mx}) - $signed({off_x[15], off_x});
            hy = $signed({my[15], my}) - $signed({off_y[15], off_y});
            if (hx == 0 && hy == 0) return 16'd0;
            if (hx == 0) return (hy < 0) ? 16'd9000 : 16'd27000;
            if (hy == 0) return (hx > 0) ? 16'd0 : 16'd18000;
            x   = longint'(hx) * (longint'(1) << PRESCALE);
            y   = longint'(hy) * (longint'(1) << PRESCALE);
            ang = '0;
            if (x < 0) begin
                // turn by half a turn into the right half plane
                x   = -x;
                y   = -y;
                ang = 32'h8000_0000;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x   = x + dx;
                    y   = y - dy;
                    ang = ang + ATAN_TAB[i];
                end else begin
                    x   = x - dx;
                    y   = y + dy;
                    ang = ang - ATAN_TAB[i];
                end
            end
            ang  = 32'd0 - ang;
            prod = {32'd0, ang} * 64'd36000 + 64'h8000_0000;
            cd   = prod[47:32];
            if (cd >= 16'd36000) cd = 16'd0;
            return cd;
        endfunction

        function void note_sample(logic [15:0] mx, logic [15:0] my);
            expected_headings.push_back(predict_heading(mx, my));
        endfunction

        function void check_heading(logic [15:0] got);
            logic [15:0] want;
            if (expected_headings.size() == 0) begin
                $error("heading_centideg: expected none, actual %0d", got);
                errors++;
            end else begin
                want = expected_headings.pop_front();
                if (want !== got) begin
                    $error("heading_centideg: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_headings.size();
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_push     = 1'b0;
    logic [15:0] i_mag_x    = '0;
    logic [15:0] i_mag_y    = '0;
    logic        i_pop      = 1'b0;
    logic        i_cfg_we   = 1'b0;
    t_cfg_idx    i_cfg_idx  = CFG_OFFSET_X;
    logic [15:0] i_cfg_data = '0;
    logic        o_full;
    logic        o_empty;
    logic [15:0] o_heading_centideg;

    heading_checker sb = new();

    int unsigned stall_cycles = 0;
    int unsigned popped       = 0;
    int unsigned hold_left    = 0;
    int unsigned pop_cycle    = 0;
    int unsigned pop_mode     = 0;

    compass_heading_from_xy_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_mag_x            (i_mag_x),
        .i_mag_y            (i_mag_y),
        .o_empty            (o_empty),
        .i_pop              (i_pop),
        .o_heading_centideg (o_heading_centideg),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: own stall pattern, plus long hold-offs to back the pipe up
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                sb.check_heading(o_heading_centideg);
                popped++;
                if (popped == 300 || popped == 800) hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                case (pop_mode)
                    0: i_pop <= 1'b1;
                    1: i_pop <= 1'($urandom_range(0, 1));
                    2: i_pop <= ($urandom_range(0, 3) == 0);
                    default: i_pop <= ($urandom_range(0, 9) != 0);
                endcase
            end
            pop_cycle++;
            if (pop_cycle % 50 == 0) pop_mode = $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("compass_heading_from_xy_top regression: fail");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] mx, logic [15:0] my);
        i_mag_x <= mx;
        i_mag_y <= my;
        i_push  <= 1'b1;
        do @(posedge i_clk); while (o_full);
        sb.note_sample(mx, my);
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_offsets(logic [15:0] ox, logic [15:0] oy);
        i_push <= 1'b0;
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OFFSET_X;
        i_cfg_data <= ox;
        @(posedge i_clk);
        sb.set_offset(CFG_OFFSET_X, ox);
        i_cfg_idx  <= CFG_OFFSET_Y;
        i_cfg_data <= oy;
        @(posedge i_clk);
        sb.set_offset(CFG_OFFSET_Y, oy);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_sample(output logic [15:0] mx, output logic [15:0] my);
        int          kind;
        logic [15:0] d;
        kind = $urandom_range(0, 9);
        mx   = 16'($urandom());
        my   = 16'($urandom());
        case (kind)
            0: mx = sb.off_x;
            1: my = sb.off_y;
            2: begin
                mx = sb.off_x + 16'($signed($urandom_range(0, 6)) - 3);
                my = sb.off_y + 16'($signed($urandom_range(0, 6)) - 3);
            end
            3: begin
                d  = 16'($urandom_range(1, 3000));
                mx = $urandom_range(0, 1) ? sb.off_x + d : sb.off_x - d;
                my = $urandom_range(0, 1) ? sb.off_y + d : sb.off_y - d;
            end
            default: ;
        endcase
    endtask

    task automatic run_random(int n);
        int          burst;
        int          gap;
        logic [15:0] mx;
        logic [15:0] my;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 24);
            end
            pick_sample(mx, my);
            send_sample(mx, my);
            burst--;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero offsets: axes, quadrants, extremes, wrap near 36000
        send_sample(16'sd0,      16'sd0);
        send_sample(16'sd0,      -16'sd1);
        send_sample(16'sd0,      16'sd1);
        send_sample(16'sd1,      16'sd0);
        send_sample(-16'sd1,     16'sd0);
        send_sample(16'sd32767,  16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0,      -16'sd32768);
        send_sample(16'sd0,      16'sd32767);
        send_sample(16'sd32767,  16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767,  -16'sd32768);
        send_sample(16'sd1,      16'sd1);
        send_sample(-16'sd1,     -16'sd1);
        send_sample(16'sd1,      -16'sd1);
        send_sample(-16'sd1,     16'sd1);
        send_sample(-16'sd5,     16'sd1);
        send_sample(-16'sd5,     -16'sd1);
        send_sample(16'sd32767,  16'sd1);
        send_sample(16'sd32767,  -16'sd1);
        send_sample(16'sd100,    16'sd1);

        write_offsets(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767,  -16'sd32768);
        run_random(PHASE_ITEMS);

        write_offsets(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767,  -16'sd32768);
        run_random(PHASE_ITEMS);

        write_offsets(16'($urandom()), 16'($urandom()));
        run_random(PHASE_ITEMS);

        write_offsets(-16'sd32768, -16'sd32768);
        run_random(PHASE_ITEMS);

        write_offsets(16'($signed($urandom_range(0, 100)) - 50),
                      16'($signed($urandom_range(0, 100)) - 50));
        run_random(PHASE_ITEMS);

        write_offsets(16'sd0, 16'sd0);
        run_random(PHASE_ITEMS);

        i_push <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("compass_heading_from_xy_top regression: pass");
        end else begin
            $display("compass_heading_from_xy_top regression: fail");
        end
        $finish;
    end

endmodule
